FILE: design/vector3_normalize_assert.svh
// Assertion macros for the vector normalizer.
// Each macro expects clk and rst_n in scope.
`ifndef VECTOR3_NORMALIZE_ASSERT_SVH
`define VECTOR3_NORMALIZE_ASSERT_SVH

// Implication within the same cycle.
`define VN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle.
`define VN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/vn_pkg.sv
`default_nettype none

package vn_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int OUT_FRAC  = 14;
    localparam int OUT_WIDTH = OUT_FRAC + 2;
    localparam int SQ_W      = 2 * IN_WIDTH;
    localparam int SUM_W     = 2 * IN_WIDTH + 2;
    localparam int RW        = 2 * IN_WIDTH + 2 * OUT_FRAC + 6;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] comp_x;
        logic signed [IN_WIDTH-1:0] comp_y;
        logic signed [IN_WIDTH-1:0] comp_z;
    } vn_in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] unit_x;
        logic signed [OUT_WIDTH-1:0] unit_y;
        logic signed [OUT_WIDTH-1:0] unit_z;
        logic                        zero_length;
    } vn_out_t;

    typedef struct packed {
        logic [SQ_W-1:0] sq;
        logic            neg;
    } vn_sq_lane_t;

    typedef struct packed {
        vn_sq_lane_t [2:0] lane;
        logic              zero;
    } vn_sq_t;

    typedef struct packed {
        logic signed [RW-1:0] rem;
        logic signed [RW-1:0] prod;
        logic [OUT_FRAC:0]    k;
        logic                 neg;
    } vn_lane_t;

    typedef struct packed {
        vn_lane_t [2:0]   lane;
        logic [SUM_W-1:0] sum;
        logic             zero;
    } vn_work_t;

endpackage

`default_nettype wire

FILE: design/vn_square.sv
`default_nettype none

module vn_square
    import vn_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  wire vn_in_t in_data,
    output logic        valid_reg,
    output vn_sq_t      data_reg
);

    logic signed [IN_WIDTH-1:0] comp [3];
    vn_sq_t                     data_next;

    always_comb
    begin
        logic [IN_WIDTH-1:0] mag;
        comp[0] = in_data.comp_x;
        comp[1] = in_data.comp_y;
        comp[2] = in_data.comp_z;
        mag = '0;
        for (int i = 0; i < 3; i++)
        begin
            // The magnitude of the most negative value still fits unsigned.
            mag = comp[i][IN_WIDTH-1] ? IN_WIDTH'(-comp[i]) : IN_WIDTH'(comp[i]);
            data_next.lane[i].sq  = SQ_W'(mag) * SQ_W'(mag);
            data_next.lane[i].neg = comp[i][IN_WIDTH-1];
        end
        data_next.zero = (in_data.comp_x == '0) && (in_data.comp_y == '0)
                         && (in_data.comp_z == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: design/vn_setup.sv
`default_nettype none

module vn_setup
    import vn_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  wire vn_sq_t in_data,
    output logic        valid_reg,
    output vn_work_t    data_reg
);

    vn_work_t         data_next;
    logic [SUM_W-1:0] sum;

    // The search starts from k = 0, where q = 2k - 1 = -1: the residual is
    // T - S with T = 4 c^2 2^(2F), and the running product q*S is -S.
    always_comb
    begin
        sum = SUM_W'(in_data.lane[0].sq) + SUM_W'(in_data.lane[1].sq)
              + SUM_W'(in_data.lane[2].sq);
        for (int i = 0; i < 3; i++)
        begin
            data_next.lane[i].rem  = ($signed(RW'(in_data.lane[i].sq)) <<< (2 * OUT_FRAC + 2))
                                     - $signed(RW'(sum));
            data_next.lane[i].prod = -$signed(RW'(sum));
            data_next.lane[i].k    = '0;
            data_next.lane[i].neg  = in_data.lane[i].neg;
        end
        data_next.sum  = sum;
        data_next.zero = in_data.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: design/vn_root_step.sv
`default_nettype none

module vn_root_step
    import vn_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire vn_work_t in_data,
    output logic          valid_reg,
    output vn_work_t      data_reg
);

    vn_work_t data_next;

    // Setting bit BIT of k moves q up by 2^(BIT+1), so q^2*S grows by
    // 2^(BIT+2)*q*S + 2^(2*BIT+2)*S. The bit is kept while that growth
    // still fits in the residual.
    always_comb
    begin
        logic signed [RW-1:0] grow;
        logic                 take;
        grow = '0;
        take = 1'b0;
        data_next = in_data;
        for (int i = 0; i < 3; i++)
        begin
            grow = (in_data.lane[i].prod <<< (BIT + 2))
                   + ($signed(RW'(in_data.sum)) <<< (2 * BIT + 2));
            take = !in_data.lane[i].k[OUT_FRAC] && (in_data.lane[i].rem >= grow);
            if (take)
            begin
                data_next.lane[i].rem    = in_data.lane[i].rem - grow;
                data_next.lane[i].prod   = in_data.lane[i].prod
                                           + ($signed(RW'(in_data.sum)) <<< (BIT + 1));
                data_next.lane[i].k[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: design/vector3_normalize.sv
// A beat passes the square, setup and square-root stages, then the output register, in order.
// Throughput: one vector per cycle while the output is not stalled; each pipeline stage handles one beat.
// The per-bit square-root search, one result bit per stage, sets the depth.
// Reset (rst_n low, asynchronous) empties every stage; data registers are not cleared.
`default_nettype none

`include "vector3_normalize_assert.svh"

module vector3_normalize
    import vn_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    vec_valid,
    output logic         vec_ready,
    input  wire vn_in_t  vec,
    output logic         unit_valid,
    input  wire logic    unit_ready,
    output vn_out_t      unit
);

    // Number of square-root stages: one per result bit, most significant first.
    localparam int NSTEP = OUT_FRAC + 1;

    // Pipeline registers. Each stage carries a valid bit, and a stage loads
    // whenever it is empty or its contents move on in the same cycle, so a
    // bubble is squeezed out and a stalled beat is held in place.
    logic     sq_valid;
    vn_sq_t   sq_data;
    logic     en_sq;

    logic     st_valid [NSTEP+1];
    vn_work_t st_data  [NSTEP+1];
    logic     st_en    [NSTEP+1];

    logic     out_valid_reg;
    vn_out_t  out_reg;
    vn_out_t  out_next;
    logic     en_out;

    // Enable chain, resolved from the output back to the input.
    assign en_out = !out_valid_reg || unit_ready;

    always_comb
    begin
        st_en[NSTEP] = !st_valid[NSTEP] || en_out;
        for (int j = NSTEP - 1; j >= 0; j--)
            st_en[j] = !st_valid[j] || st_en[j+1];
    end

    assign en_sq     = !sq_valid || st_en[0];
    assign vec_ready = en_sq;

    // Stage one: component magnitudes and their squares.
    vn_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_sq),
        .in_valid  (vec_valid),
        .in_data   (vec),
        .valid_reg (sq_valid),
        .data_reg  (sq_data)
    );

    // Stage two: sum of squares and the starting residual for each lane.
    vn_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (st_en[0]),
        .in_valid  (sq_valid),
        .in_data   (sq_data),
        .valid_reg (st_valid[0]),
        .data_reg  (st_data[0])
    );

    // The rounded quotient is the largest k with (2k-1)^2 * S <= 4 c^2 2^(2F).
    // The search settles one bit of k per stage, tracking the residual and
    // q*S with shifts and adds only, so no stage needs a multiplier.
    for (genvar j = 0; j < NSTEP; j++)
    begin : g_step
        vn_root_step #(
            .BIT (OUT_FRAC - j)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (st_en[j+1]),
            .in_valid  (st_valid[j]),
            .in_data   (st_data[j]),
            .valid_reg (st_valid[j+1]),
            .data_reg  (st_data[j+1])
        );
    end

    // Output stage: apply the signs; a zero vector gives zeros and the flag.
    always_comb
    begin
        logic signed [OUT_WIDTH-1:0] mag [3];
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = $signed(OUT_WIDTH'(st_data[NSTEP].lane[i].k));
            if (st_data[NSTEP].zero)
                mag[i] = '0;
            else if (st_data[NSTEP].lane[i].neg)
                mag[i] = -mag[i];
        end
        out_next.unit_x      = mag[0];
        out_next.unit_y      = mag[1];
        out_next.unit_z      = mag[2];
        out_next.zero_length = st_data[NSTEP].zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= st_valid[NSTEP];
    end

    always_ff @(posedge clk)
    begin
        if (en_out && st_valid[NSTEP])
            out_reg <= out_next;
    end

    assign unit_valid = out_valid_reg;
    assign unit       = out_reg;

    // A zero vector must come out with all components cleared.
    `VN_ASSERT_NOW(a_zero_clears, out_valid_reg && out_reg.zero_length,
        (out_reg.unit_x == '0) && (out_reg.unit_y == '0) && (out_reg.unit_z == '0),
        "zero-length beat with nonzero components")

    // The x component of a normalized vector never exceeds one in magnitude.
    `VN_ASSERT_NOW(a_unit_bound, out_valid_reg,
        ($signed(out_reg.unit_x) <= $signed(OUT_WIDTH'(1 << OUT_FRAC)))
        && ($signed(out_reg.unit_x) >= -$signed(OUT_WIDTH'(1 << OUT_FRAC))),
        "component magnitude above one")

    // The input side only stalls when a result is waiting at the output.
    `VN_ASSERT_NOW(a_stall_cause, !vec_ready, out_valid_reg && !unit_ready,
        "input stalled without output back-pressure")

    // The last step stage, holding a beat and able to move, passes it on to the output register.
    `VN_ASSERT_NEXT(a_last_moves, st_valid[NSTEP] && en_out, out_valid_reg,
        "beat lost between last step and output register")

endmodule

`default_nettype wire

FILE: tb/tb_vector3_normalize.sv
`timescale 1ns / 1ps

module tb_vector3_normalize
    import vn_pkg::*;
();

    // Pipeline depth in register stages; used for the hold-off length and the drain wait.
    localparam int PIPE_LATENCY = OUT_FRAC + 4;

    logic    clk;
    logic    rst_n;
    logic    vec_valid;
    logic    vec_ready;
    vn_in_t  vec;
    logic    unit_valid;
    logic    unit_ready;
    vn_out_t unit;

    vector3_normalize dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .vec_valid  (vec_valid),
        .vec_ready  (vec_ready),
        .vec        (vec),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit       (unit)
    );

    // Vectors waiting to be driven, and unit vectors waiting to come out.
    vn_in_t  pending_vecs[$];
    vn_out_t expected_units[$];

    int  mismatch_count;
    int  beats_sent;
    int  beats_checked;
    int  zero_vectors;
    bit  hold_off;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Rounded magnitude of |c| * 2^OUT_FRAC / sqrt(s). A candidate k is kept
    // while (2k-1)^2 * s <= 4 * c^2 * 2^(2*OUT_FRAC), which is round-half-up
    // on the exact real quotient without ever forming the square root.
    function automatic logic [OUT_FRAC:0] unit_magnitude(input logic [63:0] mag,
                                                         input logic [63:0] s);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [63:0]  cand;
        logic [63:0]  odd;
        logic [63:0]  k;
        k   = 0;
        lhs = (128'(mag * mag)) << (2 * OUT_FRAC + 2);
        for (int b = OUT_FRAC; b >= 0; b--)
        begin
            cand = k | (64'd1 << b);
            if (cand <= (64'd1 << OUT_FRAC))
            begin
                odd = 2 * cand - 1;
                rhs = 128'(odd * odd) * 128'(s);
                if (lhs >= rhs)
                    k = cand;
            end
        end
        return k[OUT_FRAC:0];
    endfunction

    function automatic vn_out_t normalize_vector(input vn_in_t v);
        vn_out_t r;
        logic signed [IN_WIDTH-1:0] comp[3];
        logic [63:0] mag[3];
        logic [63:0] sum_sq;
        logic [OUT_FRAC:0] k;
        logic signed [OUT_WIDTH-1:0] res[3];
        comp[0] = v.comp_x;
        comp[1] = v.comp_y;
        comp[2] = v.comp_z;
        sum_sq  = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = comp[i] < 0 ? 64'(-64'(comp[i])) : 64'(comp[i]);
            sum_sq += mag[i] * mag[i];
        end
        r = '0;
        if (sum_sq == 0)
        begin
            r.zero_length = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            k = unit_magnitude(mag[i], sum_sq);
            // The sign goes on after rounding, so a tie rounds away from zero.
            res[i] = comp[i] < 0 ? -$signed({1'b0, k}) : $signed({1'b0, k});
        end
        r.unit_x = res[0];
        r.unit_y = res[1];
        r.unit_z = res[2];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Driver: bursts of back-to-back beats separated by random gaps. Valid is
    // only lowered or reloaded once the current beat has been taken.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_valid  <= 1'b0;
            vec        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!vec_valid || vec_ready)
        begin
            if (gap_left > 0)
            begin
                vec_valid <= 1'b0;
                gap_left  <= gap_left - 1;
            end
            else if (pending_vecs.size() > 0)
            begin
                vec       <= pending_vecs.pop_front();
                vec_valid <= 1'b1;
                beats_sent++;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                vec_valid <= 1'b0;
            end
        end
    end

    // The prediction is made when the block accepts a beat, so the queue of
    // expected unit vectors stays in acceptance order.
    always @(posedge clk)
    begin
        if (rst_n && vec_valid && vec_ready)
        begin
            expected_units.push_back(normalize_vector(vec));
            if (vec == '0)
                zero_vectors++;
        end
    end

    // Receiver stall pattern: a repeating mask whose phase wanders, plus an
    // optional long hold-off that lets the pipeline fill up completely.
    int stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ready  <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_off)
                unit_ready <= 1'b0;
            else if (stall_phase % 512 < 128)
                unit_ready <= 1'b1;
            else
                unit_ready <= (stall_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: every output beat is compared against the oldest expectation.
    always @(posedge clk)
    begin
        vn_out_t want;
        if (rst_n && unit_valid && unit_ready)
        begin
            if (expected_units.size() == 0)
            begin
                $display("[%0t] output beat with no vector pending", $time);
                mismatch_count++;
            end
            else
            begin
                want = expected_units.pop_front();
                beats_checked++;
                if (unit.unit_x !== want.unit_x)
                    report_mismatch("unit_x", unit.unit_x, want.unit_x);
                if (unit.unit_y !== want.unit_y)
                    report_mismatch("unit_y", unit.unit_y, want.unit_y);
                if (unit.unit_z !== want.unit_z)
                    report_mismatch("unit_z", unit.unit_z, want.unit_z);
                if (unit.zero_length !== want.zero_length)
                    report_mismatch("zero_length", unit.zero_length, want.zero_length);
            end
        end
    end

    function automatic vn_in_t make_vec(input int x, input int y, input int z);
        vn_in_t v;
        v.comp_x = x[IN_WIDTH-1:0];
        v.comp_y = y[IN_WIDTH-1:0];
        v.comp_z = z[IN_WIDTH-1:0];
        return v;
    endfunction

    // Random component: full range half of the time, otherwise tiny, zero or at an extreme,
    // so that very short and very long vectors both come up often.
    function automatic int random_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 8) - 4;
            1: return ($urandom_range(0, 1) != 0) ? -32768 : 32767;
            2: return 0;
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    initial
    begin
        int sel;
        mismatch_count = 0;
        beats_sent     = 0;
        beats_checked  = 0;
        zero_vectors   = 0;
        hold_off       = 1'b0;
        rst_n          = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats: zero vector, axes, extremes, ties and sign cases.
        pending_vecs.push_back(make_vec(0, 0, 0));
        pending_vecs.push_back(make_vec(256, 0, 0));
        pending_vecs.push_back(make_vec(0, -256, 0));
        pending_vecs.push_back(make_vec(0, 0, 1));
        pending_vecs.push_back(make_vec(-1, 0, 0));
        pending_vecs.push_back(make_vec(32767, 0, 0));
        pending_vecs.push_back(make_vec(-32768, 0, 0));
        pending_vecs.push_back(make_vec(0, 0, -32768));
        pending_vecs.push_back(make_vec(-32768, -32768, -32768));
        pending_vecs.push_back(make_vec(32767, 32767, 32767));
        pending_vecs.push_back(make_vec(-32768, 32767, -32768));
        pending_vecs.push_back(make_vec(1, 1, 1));
        pending_vecs.push_back(make_vec(1, -1, 0));
        pending_vecs.push_back(make_vec(3, 4, 0));
        pending_vecs.push_back(make_vec(-3, 0, 4));
        pending_vecs.push_back(make_vec(2, 2, 1));
        pending_vecs.push_back(make_vec(1, 32767, 0));
        pending_vecs.push_back(make_vec(-1, -32768, 1));
        pending_vecs.push_back(make_vec(0, 0, 0));
        pending_vecs.push_back(make_vec(21845, -10922, 5461));
        pending_vecs.push_back(make_vec(-21846, 10921, -5462));

        for (int i = 0; i < 1300; i++)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                pending_vecs.push_back(make_vec(0, 0, 0));
            else
                pending_vecs.push_back(make_vec(random_comp(), random_comp(), random_comp()));
        end

        // Long receiver hold-off partway through, while the driver keeps
        // offering beats so that the block has to stall its input.
        wait (beats_sent >= 400);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (3 * PIPE_LATENCY + 40) @(posedge clk);
        hold_off <= 1'b0;

        wait (pending_vecs.size() == 0 && !vec_valid);
        wait (expected_units.size() == 0);
        repeat (PIPE_LATENCY + 10) @(posedge clk);

        $display("Sent %0d vectors (%0d all-zero), checked %0d unit vectors.",
                 beats_sent, zero_vectors, beats_checked);
        $display("Covered axes, full-scale extremes, rounding ties, a full-pipeline stall.");
        if (mismatch_count == 0 && expected_units.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d unit vectors outstanding.", expected_units.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
